### design/gwm_pkg.sv
// Shared types, constants and helpers for the glob wildcard matcher.
package gwm_pkg;

  localparam int MASK_TOKENS = 32;
  localparam int IDX_W       = (MASK_TOKENS > 1) ? $clog2(MASK_TOKENS) : 1;
  localparam int CNT_W       = $clog2(MASK_TOKENS + 1);

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef enum logic [1:0] {
    CMD_MASK  = 2'd0,
    CMD_SUBJ  = 2'd1,
    CMD_END   = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_LIT = 2'd0,
    KIND_ANY = 2'd1,
    KIND_RUN = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
  } tok_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic             step;
    logic             restart;
    logic [7:0]       fc;
    logic             wr0_en;
    logic [IDX_W-1:0] wr0_idx;
    tok_t             wr0_tok;
    logic             wr1_en;
    logic [IDX_W-1:0] wr1_idx;
    tok_t             wr1_tok;
    logic [CNT_W-1:0] eff_count;
  } ctl_t;

  function automatic logic [7:0] fold_ch(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) r = c + CASE_OFFSET;
    return r;
  endfunction

endpackage

### design/gwm_cell.sv
// One mask position: stored token, active bit, run closure and step logic.
module gwm_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [gwm_pkg::IDX_W-1:0] cell_idx,
  input  gwm_pkg::ctl_t            ctl,
  input  logic                     clos_in,
  output logic                     clos_out,
  input  logic                     hit_in,
  output logic                     hit_out,
  output logic                     fin_out
);
  import gwm_pkg::*;

  tok_t tok_r, tok_nxt;
  logic act_r, act_nxt;

  logic wr_here0, wr_here1;
  tok_t eff_tok;
  logic valid, closed, is_run;

  always_comb begin
    wr_here0 = ctl.wr0_en && (ctl.wr0_idx == cell_idx);
    wr_here1 = ctl.wr1_en && (ctl.wr1_idx == cell_idx);
    // a backslash finished in the same item is used right away
    eff_tok  = wr_here0 ? ctl.wr0_tok : tok_r;
    valid    = {1'b0, cell_idx} < ctl.eff_count;
    closed   = act_r | clos_in;
    is_run   = valid && (eff_tok.kind == KIND_RUN);
    clos_out = closed & is_run;
    hit_out  = closed && valid &&
               ((eff_tok.kind == KIND_ANY) ||
                ((eff_tok.kind == KIND_LIT) && (eff_tok.ch == ctl.fc)));
    fin_out  = closed && ({1'b0, cell_idx} == ctl.eff_count);
  end

  always_comb begin
    if (ctl.restart) begin
      act_nxt = (cell_idx == '0);
    end else if (ctl.step) begin
      act_nxt = (closed & is_run) | hit_in;
    end else begin
      act_nxt = act_r;
    end
  end

  always_comb begin
    if (wr_here0) begin
      tok_nxt = ctl.wr0_tok;
    end else if (wr_here1) begin
      tok_nxt = ctl.wr1_tok;
    end else begin
      tok_nxt = tok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= (cell_idx == '0);
    end else begin
      act_r <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

endmodule

### design/glob_wildcard_matcher.sv
// A report is registered onto out_valid when its end item is accepted, via the skid entry if out is stalled.
// Throughput: one item per cycle while in_stall is low, any command mix; the run-closure chain through
//   all mask cells plus the step compare sets the cycle time.
// Reset (synchronous, rst_n low): empty mask, no pending escape, no overflow,
//   only position zero active, output empty. Token store is not cleared.
module glob_wildcard_matcher (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  input  logic [7:0] in_char_code,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_matched,
  output logic       out_mask_overflow
);
  import gwm_pkg::*;

  localparam logic [CNT_W:0] CAP = (CNT_W+1)'(MASK_TOKENS);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             esc_r, esc_nxt;
  logic             ovf_r, ovf_nxt;
  logic             act_end_r, act_end_nxt;

  logic out_valid_r, out_matched_r, out_ovf_r;
  logic skid_valid_r, skid_matched_r, skid_ovf_r;

  logic       in_fire, out_fire;
  cmd_t       cmd;
  logic [1:0] n_push;
  tok_t       t0, t1;
  logic [CNT_W:0] sum;
  logic       fin_push;
  ctl_t       ctl;

  logic [MASK_TOKENS:0]   clos_chain, hit_chain;
  logic [MASK_TOKENS-1:0] fin_vec;
  logic closed_end, res_valid, res_matched;

  assign in_stall  = skid_valid_r;
  assign in_fire   = in_valid & ~skid_valid_r;
  assign out_fire  = out_valid_r & ~out_stall;
  assign cmd       = cmd_t'(in_command);

  // token generation from the mask parser
  always_comb begin
    n_push  = 2'd0;
    t0      = tok_t'{kind: KIND_LIT, ch: CH_BSLASH};
    t1      = tok_t'{kind: KIND_LIT, ch: CH_BSLASH};
    esc_nxt = esc_r;
    case (cmd)
      CMD_MASK: begin
        if (esc_r) begin
          if (in_char_code == CH_QUEST || in_char_code == CH_STAR) begin
            n_push  = 2'd1;
            t0      = tok_t'{kind: KIND_LIT, ch: in_char_code};
            esc_nxt = 1'b0;
          end else if (in_char_code == CH_BSLASH) begin
            n_push  = in_last ? 2'd2 : 2'd1;
            esc_nxt = ~in_last;
          end else begin
            n_push  = 2'd2;
            t1      = tok_t'{kind: KIND_LIT, ch: fold_ch(in_char_code)};
            esc_nxt = 1'b0;
          end
        end else begin
          esc_nxt = 1'b0;
          if (in_char_code == CH_BSLASH) begin
            n_push  = in_last ? 2'd1 : 2'd0;
            esc_nxt = ~in_last;
          end else if (in_char_code == CH_QUEST) begin
            n_push = 2'd1;
            t0     = tok_t'{kind: KIND_ANY, ch: 8'h00};
          end else if (in_char_code == CH_STAR) begin
            n_push = 2'd1;
            t0     = tok_t'{kind: KIND_RUN, ch: 8'h00};
          end else begin
            n_push = 2'd1;
            t0     = tok_t'{kind: KIND_LIT, ch: fold_ch(in_char_code)};
          end
        end
      end
      CMD_SUBJ, CMD_END: begin
        n_push  = esc_r ? 2'd1 : 2'd0;
        esc_nxt = 1'b0;
      end
      CMD_CLEAR: begin
        esc_nxt = 1'b0;
      end
      default: begin
        esc_nxt = esc_r;
      end
    endcase
  end

  always_comb begin
    sum      = {1'b0, count_r} + (CNT_W+1)'(n_push);
    fin_push = (cmd != CMD_MASK) && esc_r && ({1'b0, count_r} < CAP);

    ctl.step      = in_fire && (cmd == CMD_SUBJ);
    ctl.restart   = in_fire && (cmd == CMD_END || cmd == CMD_CLEAR);
    ctl.fc        = fold_ch(in_char_code);
    ctl.wr0_en    = in_fire && (cmd != CMD_CLEAR) && (n_push != 2'd0) &&
                    ({1'b0, count_r} < CAP);
    ctl.wr0_idx   = count_r[IDX_W-1:0];
    ctl.wr0_tok   = t0;
    ctl.wr1_en    = in_fire && (n_push == 2'd2) &&
                    (({1'b0, count_r} + (CNT_W+1)'(1)) < CAP);
    ctl.wr1_idx   = IDX_W'(count_r + CNT_W'(1));
    ctl.wr1_tok   = t1;
    ctl.eff_count = count_r + CNT_W'(fin_push);

    if (cmd == CMD_CLEAR) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else begin
      count_nxt = (sum > CAP) ? CNT_W'(MASK_TOKENS) : sum[CNT_W-1:0];
      ovf_nxt   = ovf_r | (sum > CAP);
    end
  end

  // active bit of the position past the last cell
  always_comb begin
    if (ctl.restart) begin
      act_end_nxt = 1'b0;
    end else if (ctl.step) begin
      act_end_nxt = hit_chain[MASK_TOKENS];
    end else begin
      act_end_nxt = act_end_r;
    end
  end

  assign clos_chain[0] = 1'b0;
  assign hit_chain[0]  = 1'b0;

  genvar g;
  generate
    for (g = 0; g < MASK_TOKENS; g++) begin : g_cell
      gwm_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_idx (IDX_W'(g)),
        .ctl      (ctl),
        .clos_in  (clos_chain[g]),
        .clos_out (clos_chain[g+1]),
        .hit_in   (hit_chain[g]),
        .hit_out  (hit_chain[g+1]),
        .fin_out  (fin_vec[g])
      );
    end
  endgenerate

  always_comb begin
    closed_end  = act_end_r | clos_chain[MASK_TOKENS];
    res_matched = (|fin_vec) |
                  (closed_end && (ctl.eff_count == CNT_W'(MASK_TOKENS)));
    res_valid   = in_fire && (cmd == CMD_END);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      esc_r     <= 1'b0;
      ovf_r     <= 1'b0;
      act_end_r <= 1'b0;
    end else begin
      act_end_r <= act_end_nxt;
      if (in_fire) begin
        count_r <= count_nxt;
        esc_r   <= esc_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || out_fire) begin
      out_valid_r <= res_valid;
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_matched_r <= skid_matched_r;
        out_ovf_r     <= skid_ovf_r;
      end
    end else if (!out_valid_r || out_fire) begin
      out_matched_r <= res_matched;
      out_ovf_r     <= ovf_nxt;
    end else begin
      skid_matched_r <= res_matched;
      skid_ovf_r     <= ovf_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_matched       = out_matched_r;
  assign out_mask_overflow = out_ovf_r;

endmodule

### tb/tb.sv
// Self-checking testbench for glob_wildcard_matcher: streamed masks and subjects checked against a bit-vector predictor.
module tb;
  import gwm_pkg::*;

  localparam int ITEMS_TARGET = 850;
  localparam int REPORT_LIMIT = 10;
  localparam int DRAIN_LIMIT  = 5000;

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  typedef enum {STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_command = CMD_CLEAR;
  logic [7:0] in_char_code = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_matched;
  logic       out_mask_overflow;

  glob_wildcard_matcher dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_char_code      (in_char_code),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_matched       (out_matched),
    .out_mask_overflow (out_mask_overflow)
  );

  // Predictor state: token list, escape flag, live prefix positions, overflow.
  kind_t                tok_kind [MASK_TOKENS];
  logic [7:0]           tok_ch   [MASK_TOKENS];
  int                   tok_cnt;
  bit                   esc_wait;
  bit                   ovf_seen;
  logic [MASK_TOKENS:0] live;

  verdict_t   verdict_q [$];
  logic [7:0] mask_q [$];
  logic [7:0] subj_q [$];

  int items_done = 0;
  int mismatches = 0;
  int burst_left = 0;
  bit steady = 1'b0;
  int hold_req = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 200000);
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------- predictor ----------------
  function automatic logic [7:0] lower_byte(logic [7:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_OFFSET : c;
  endfunction

  function automatic void store_token(kind_t k, logic [7:0] c);
    if (tok_cnt < MASK_TOKENS) begin
      tok_kind[tok_cnt] = k;
      tok_ch[tok_cnt]   = c;
      tok_cnt++;
    end else begin
      ovf_seen = 1'b1;
    end
  endfunction

  function automatic void flush_escape();
    if (esc_wait) begin
      esc_wait = 1'b0;
      store_token(KIND_LIT, CH_BSLASH);
    end
  endfunction

  // A run token may match nothing, so activity falls through it.
  function automatic logic [MASK_TOKENS:0] with_runs(logic [MASK_TOKENS:0] s);
    logic [MASK_TOKENS:0] r;
    r = s;
    for (int i = 0; i < tok_cnt; i++)
      if (r[i] && tok_kind[i] == KIND_RUN) r[i+1] = 1'b1;
    return r;
  endfunction

  function automatic void matcher_reset();
    tok_cnt  = 0;
    esc_wait = 1'b0;
    ovf_seen = 1'b0;
    live     = 1;
  endfunction

  function automatic void predict_item(cmd_t cmd, logic [7:0] ch, logic last);
    logic [MASK_TOKENS:0] cur;
    logic [MASK_TOKENS:0] nxt;
    bit used;
    verdict_t v;
    case (cmd)
      CMD_MASK: begin
        used = 1'b0;
        if (esc_wait) begin
          esc_wait = 1'b0;
          if (ch == CH_QUEST || ch == CH_STAR) begin
            store_token(KIND_LIT, ch);
            used = 1'b1;
          end else begin
            store_token(KIND_LIT, CH_BSLASH);
          end
        end
        if (!used) begin
          if (ch == CH_BSLASH) esc_wait = 1'b1;
          else if (ch == CH_QUEST) store_token(KIND_ANY, 8'h00);
          else if (ch == CH_STAR) store_token(KIND_RUN, 8'h00);
          else store_token(KIND_LIT, ch);
        end
        if (last) flush_escape();
      end
      CMD_SUBJ: begin
        flush_escape();
        cur = with_runs(live);
        nxt = '0;
        for (int i = 0; i < tok_cnt; i++) begin
          if (cur[i]) begin
            if (tok_kind[i] == KIND_RUN) nxt[i] = 1'b1;
            else if (tok_kind[i] == KIND_ANY || lower_byte(tok_ch[i]) == lower_byte(ch))
              nxt[i+1] = 1'b1;
          end
        end
        live = nxt;
      end
      CMD_END: begin
        flush_escape();
        cur = with_runs(live);
        v.matched  = cur[tok_cnt];
        v.overflow = ovf_seen;
        verdict_q.push_back(v);
        live = 1;
      end
      default: matcher_reset();
    endcase
  endfunction

  // ---------------- driving ----------------
  task automatic send_item(cmd_t cmd, logic [7:0] ch, logic last);
    @(negedge clk);
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_char_code <= ch;
    in_last      <= last;
    do @(posedge clk); while (in_stall);
    predict_item(cmd, ch, last);
    items_done++;
  endtask

  // Bursty sender; steady mode offers back to back.
  task automatic offer(cmd_t cmd, logic [7:0] ch, logic last);
    int gap;
    if (!steady) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 3);
        burst_left = $urandom_range(1, 24);
        if (gap > 0) begin
          @(negedge clk);
          in_valid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
      burst_left--;
    end
    send_item(cmd, ch, last);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  // ---------------- receiver ----------------
  initial begin : stall_pattern
    stall_mode_t mode;
    int span;
    int hold;
    int tick;
    mode = STALL_NONE;
    span = 0;
    hold = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_req > 0) begin
        hold = hold_req;
        hold_req = 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        if (span == 0) begin
          mode = stall_mode_t'($urandom_range(0, 3));
          span = $urandom_range(5, 40);
        end
        span--;
        case (mode)
          STALL_NONE:     out_stall <= 1'b0;
          STALL_SPARSE:   out_stall <= ($urandom_range(0, 2) == 0);
          STALL_PERIODIC: out_stall <= (tick % 4 == 3);
          default:        out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // ---------------- checking ----------------
  function automatic void flag_mismatch(string what, logic exp_v, logic got_v);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("MISMATCH %s: expected %b got %b at %0t", what, exp_v, got_v, $time);
  endfunction

  always @(posedge clk) begin : verdict_check
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        flag_mismatch("report with none pending, matched", 1'bx, out_matched);
      end else begin
        want = verdict_q.pop_front();
        if (out_matched !== want.matched)
          flag_mismatch("matched", want.matched, out_matched);
        if (out_mask_overflow !== want.overflow)
          flag_mismatch("mask_overflow", want.overflow, out_mask_overflow);
      end
    end
  end

  // ---------------- stimulus helpers ----------------
  function automatic logic [7:0] pick_mask_char();
    int r;
    r = $urandom_range(0, 19);
    if (r < 3) return CH_STAR;
    if (r < 5) return CH_QUEST;
    if (r < 7) return CH_BSLASH;
    if (r < 10) return "a";
    if (r < 12) return "B";
    if (r < 14) return "c";
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_filler();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return "a";
      1: return "A";
      2: return "b";
      3: return "C";
      4: return CH_STAR;
      5: return CH_QUEST;
      6: return CH_BSLASH;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] flip_case(logic [7:0] c);
    logic [7:0] l;
    l = lower_byte(c);
    if (l >= "a" && l <= "z" && $urandom_range(0, 1) == 1) return c ^ CASE_OFFSET;
    return c;
  endfunction

  // Subject that follows the mask text, optionally with one byte spoiled, or random filler if not following.
  function automatic void build_subject(bit follow);
    logic [7:0] c;
    subj_q.delete();
    if (!follow) begin
      repeat ($urandom_range(0, 8)) subj_q.push_back(pick_filler());
      return;
    end
    for (int i = 0; i < mask_q.size(); i++) begin
      c = mask_q[i];
      if (c == CH_STAR) begin
        repeat ($urandom_range(0, 3)) subj_q.push_back(pick_filler());
      end else if (c == CH_QUEST) begin
        subj_q.push_back(8'($urandom_range(0, 255)));
      end else if (c == CH_BSLASH) begin
        if (i + 1 < mask_q.size() && (mask_q[i+1] == CH_QUEST || mask_q[i+1] == CH_STAR)) begin
          i++;
          subj_q.push_back(mask_q[i]);
        end else begin
          subj_q.push_back(CH_BSLASH);
        end
      end else begin
        subj_q.push_back(flip_case(c));
      end
    end
    if ($urandom_range(0, 4) == 0 && subj_q.size() > 0)
      subj_q[$urandom_range(0, subj_q.size() - 1)] = pick_filler();
  endfunction

  // ---------------- tests ----------------
  task automatic test_empty_and_runs();
    offer(CMD_END, 8'h00, 1'b0);
    offer(CMD_MASK, CH_STAR, 1'b1);
    offer(CMD_END, 8'hFF, 1'b1);
    offer(CMD_SUBJ, 8'hFF, 1'b0);
    offer(CMD_END, 8'h00, 1'b0);
  endtask

  // Escaped star, backslash before a plain byte, trailing backslash.
  task automatic test_escapes();
    offer(CMD_CLEAR, 8'h00, 1'b0);
    offer(CMD_MASK, CH_BSLASH, 1'b0);
    offer(CMD_MASK, CH_STAR, 1'b0);
    offer(CMD_MASK, CH_QUEST, 1'b0);
    offer(CMD_MASK, "Z", 1'b0);
    offer(CMD_MASK, CH_BSLASH, 1'b0);
    offer(CMD_MASK, "x", 1'b0);
    offer(CMD_MASK, CH_BSLASH, 1'b1);
    offer(CMD_SUBJ, CH_STAR, 1'b0);
    offer(CMD_SUBJ, 8'h00, 1'b0);
    offer(CMD_SUBJ, "z", 1'b0);
    offer(CMD_SUBJ, CH_BSLASH, 1'b0);
    offer(CMD_SUBJ, "X", 1'b0);
    offer(CMD_SUBJ, CH_BSLASH, 1'b0);
    offer(CMD_END, 8'h00, 1'b0);
  endtask

  // Mask grows while a subject is in flight; pending backslash at subject and end.
  task automatic test_mid_subject_edit();
    offer(CMD_CLEAR, 8'hFF, 1'b1);
    offer(CMD_MASK, "a", 1'b0);
    offer(CMD_SUBJ, "A", 1'b0);
    offer(CMD_MASK, CH_BSLASH, 1'b0);
    offer(CMD_SUBJ, CH_BSLASH, 1'b0);
    offer(CMD_END, 8'h00, 1'b0);
    offer(CMD_MASK, CH_BSLASH, 1'b0);
    offer(CMD_END, 8'h00, 1'b0);
  endtask

  // Receiver holds off while the sender keeps offering, then a full drain.
  task automatic test_backpressure();
    hold_req = 50;
    steady = 1'b1;
    offer(CMD_CLEAR, 8'h00, 1'b0);
    offer(CMD_MASK, "a", 1'b0);
    offer(CMD_MASK, CH_STAR, 1'b1);
    repeat (8) begin
      offer(CMD_SUBJ, "A", 1'b0);
      offer(CMD_END, 8'h00, 1'b0);
    end
    repeat (4) offer(CMD_END, 8'h00, 1'b0);
    steady = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_sessions();
    int mlen;
    while (items_done < ITEMS_TARGET) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(5, 20))
          offer(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
      end else begin
        if ($urandom_range(0, 7) != 0)
          offer(CMD_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        // Now and then a long mask that may overrun the token store.
        mlen = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 10);
        mask_q.delete();
        repeat (mlen) mask_q.push_back(pick_mask_char());
        foreach (mask_q[i])
          offer(CMD_MASK, mask_q[i], (i == mask_q.size() - 1) ? ($urandom_range(0, 5) != 0)
                                                              : ($urandom_range(0, 15) == 0));
        repeat ($urandom_range(1, 5)) begin
          build_subject($urandom_range(0, 4) != 0);
          foreach (subj_q[i]) offer(CMD_SUBJ, subj_q[i], 1'($urandom_range(0, 1)));
          offer(CMD_END, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  // ---------------- sequence ----------------
  initial begin : main
    int guard;
    matcher_reset();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    test_empty_and_runs();
    test_escapes();
    test_mid_subject_edit();
    test_backpressure();
    test_random_sessions();
    @(negedge clk);
    in_valid <= 1'b0;
    guard = 0;
    while (verdict_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
